// ----- rtl/core/hic_pkg.sv -----
package hic_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  localparam logic signed [12:0] OUT_LOW  = -13'sd400;
  localparam logic signed [12:0] OUT_HIGH = 13'sd2500;

  typedef struct packed {
    logic signed [10:0] temperature;
    logic        [9:0]  humidity;
  } sample_t;

  typedef struct packed {
    logic signed [12:0] apparent_temp;
    logic        [2:0]  comfort_level;
  } result_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_VALID_TEMP_MIN     = 3'd0,
    CFG_VALID_HUMIDITY_MIN = 3'd1,
    CFG_COLD_LIMIT         = 3'd2,
    CFG_COOL_LIMIT         = 3'd3,
    CFG_COMFORTABLE_LIMIT  = 3'd4,
    CFG_WARM_LIMIT         = 3'd5
  } cfg_index_t;

  typedef enum logic [2:0] {
    LVL_COLD        = 3'd0,
    LVL_COOL        = 3'd1,
    LVL_COMFORTABLE = 3'd2,
    LVL_WARM        = 3'd3,
    LVL_HOT         = 3'd4
  } comfort_t;

  typedef struct packed {
    logic signed [10:0] valid_temp_min;
    logic        [9:0]  valid_humidity_min;
    logic signed [12:0] cold_limit;
    logic signed [12:0] cool_limit;
    logic signed [12:0] comfortable_limit;
    logic signed [12:0] warm_limit;
  } cfg_t;

  // regression coefficient magnitudes scaled by 2^32
  localparam logic [63:0] COEF_MAG32 [9] = '{
    64'd37729976680, 64'd6920884003, 64'd10043990783, 64'd627563656,
    64'd52862861, 64'd70544099, 64'd9499317, 64'd3115827, 64'd15385
  };

  function automatic logic [63:0] coef_q(input logic [3:0] idx, input int unsigned frac);
    logic [63:0] m;
    int unsigned sh;
    m  = COEF_MAG32[idx];
    sh = 32 - frac;
    if (sh > 0) begin
      m = (m + (64'd1 << (sh - 1))) >> sh;
    end
    return m;
  endfunction

endpackage

// ----- rtl/core/hic_cfg_regs.sv -----
module hic_cfg_regs
  import hic_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.valid_temp_min     <= 11'sd200;
      cfg.valid_humidity_min <= 10'd400;
      cfg.cold_limit         <= 13'sd100;
      cfg.cool_limit         <= 13'sd200;
      cfg.comfortable_limit  <= 13'sd280;
      cfg.warm_limit         <= 13'sd350;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VALID_TEMP_MIN:     cfg.valid_temp_min     <= $signed(cfg_data[10:0]);
        CFG_VALID_HUMIDITY_MIN: cfg.valid_humidity_min <= cfg_data[9:0];
        CFG_COLD_LIMIT:         cfg.cold_limit         <= $signed(cfg_data);
        CFG_COOL_LIMIT:         cfg.cool_limit         <= $signed(cfg_data);
        CFG_COMFORTABLE_LIMIT:  cfg.comfortable_limit  <= $signed(cfg_data);
        CFG_WARM_LIMIT:         cfg.warm_limit         <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/heat_index_comfort_classifier_core.sv -----
// Throughput: one beat per cycle; each of the 8 stages stalls on its own, so
// bubbles are squeezed out while the result register waits on result_ready.
// The widest products are the 64-bit coefficient terms of the polynomial.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults.
module heat_index_comfort_classifier_core
  import hic_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  sample_t                sample,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int NSTG = 8;

  // signed term weights, folding the decimal scale of each monomial
  localparam logic signed [63:0] K0 = -$signed(coef_q(4'd0, COEF_FRAC_BITS) * 64'd10000);
  localparam logic signed [63:0] K1 = $signed(coef_q(4'd1, COEF_FRAC_BITS) * 64'd1000);
  localparam logic signed [63:0] K2 = $signed(coef_q(4'd2, COEF_FRAC_BITS) * 64'd1000);
  localparam logic signed [63:0] K3 = -$signed(coef_q(4'd3, COEF_FRAC_BITS) * 64'd100);
  localparam logic signed [63:0] K4 = -$signed(coef_q(4'd4, COEF_FRAC_BITS) * 64'd100);
  localparam logic signed [63:0] K5 = -$signed(coef_q(4'd5, COEF_FRAC_BITS) * 64'd100);
  localparam logic signed [63:0] K6 = $signed(coef_q(4'd6, COEF_FRAC_BITS) * 64'd10);
  localparam logic signed [63:0] K7 = $signed(coef_q(4'd7, COEF_FRAC_BITS) * 64'd10);
  localparam logic signed [63:0] K8 = -$signed(coef_q(4'd8, COEF_FRAC_BITS));

  localparam logic signed [63:0] Y_LOW  = -64'sd400000;
  localparam logic signed [63:0] Y_HIGH = 64'sd2501000;
  localparam logic [22:0]        RECIP_1000 = 23'd4294968;

  cfg_t cfg;

  assign cfg_ready = 1'b1;

  hic_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic [NSTG:1]   vld;
  logic [NSTG+1:1] en;

  always_comb begin
    en[NSTG+1] = result_ready;
    for (int k = NSTG; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign sample_ready = en[1];
  assign result_valid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= sample_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // per-stage payload
  logic signed [10:0] t1;
  logic        [9:0]  h1, h2;
  logic               poly1, poly2, poly3, poly4, poly5, poly6, poly7;
  logic signed [12:0] pass1, pass2, pass3, pass4, pass5, pass6, pass7;
  logic signed [21:0] tt2, th2;
  logic        [19:0] hh2;
  logic signed [63:0] p1_2, p2_2;
  logic signed [31:0] tth3, thh3;
  logic signed [41:0] tthh3;
  logic signed [63:0] p3_3, p4_3, p5_3, acc3;
  logic signed [63:0] p6_4, p7_4, p8_4, acc4;
  logic signed [63:0] sum5;
  logic               lo6, hi6, lo7, hi7;
  logic        [21:0] u6;
  logic        [11:0] q7;

  logic signed [63:0] y5;
  logic        [44:0] prod6;
  logic signed [12:0] apparent7;
  comfort_t           level7;

  always_comb begin
    y5        = (sum5 >>> COEF_FRAC_BITS) + 64'sd500;
    prod6     = u6 * RECIP_1000;
    apparent7 = poly7 ? (lo7 ? OUT_LOW : hi7 ? OUT_HIGH : $signed({1'b0, q7}) + OUT_LOW)
                      : pass7;
    if (apparent7 < cfg.cold_limit) begin
      level7 = LVL_COLD;
    end else if (apparent7 < cfg.cool_limit) begin
      level7 = LVL_COOL;
    end else if (apparent7 < cfg.comfortable_limit) begin
      level7 = LVL_COMFORTABLE;
    end else if (apparent7 < cfg.warm_limit) begin
      level7 = LVL_WARM;
    end else begin
      level7 = LVL_HOT;
    end
  end

  always_ff @(posedge clk) begin
    // 1: qualify, passthrough clamp
    if (en[1]) begin
      t1    <= sample.temperature;
      h1    <= sample.humidity;
      poly1 <= ($signed(sample.temperature) >= $signed(cfg.valid_temp_min)) &&
               (sample.humidity >= cfg.valid_humidity_min);
      pass1 <= ($signed(sample.temperature) < OUT_LOW) ? OUT_LOW
                                                       : 13'(sample.temperature);
    end
    // 2: square terms, linear terms
    if (en[2]) begin
      tt2   <= t1 * t1;
      th2   <= t1 * $signed({1'b0, h1});
      hh2   <= h1 * h1;
      p1_2  <= K1 * t1;
      p2_2  <= K2 * $signed({1'b0, h1});
      h2    <= h1;
      poly2 <= poly1;
      pass2 <= pass1;
    end
    // 3: cubic/quartic monomials, quadratic terms
    if (en[3]) begin
      tth3  <= tt2 * $signed({1'b0, h2});
      thh3  <= th2 * $signed({1'b0, h2});
      tthh3 <= tt2 * $signed({1'b0, hh2});
      p3_3  <= K3 * th2;
      p4_3  <= K4 * tt2;
      p5_3  <= K5 * $signed({1'b0, hh2});
      acc3  <= K0 + p1_2 + p2_2;
      poly3 <= poly2;
      pass3 <= pass2;
    end
    // 4: high-order terms
    if (en[4]) begin
      p6_4  <= K6 * tth3;
      p7_4  <= K7 * thh3;
      p8_4  <= K8 * tthh3;
      acc4  <= acc3 + p3_3 + p4_3 + p5_3;
      poly4 <= poly3;
      pass4 <= pass3;
    end
    // 5: final sum
    if (en[5]) begin
      sum5  <= acc4 + p6_4 + p7_4 + p8_4;
      poly5 <= poly4;
      pass5 <= pass4;
    end
    // 6: drop fraction with half-up rounding, clamp, offset to unsigned
    if (en[6]) begin
      lo6   <= y5 < Y_LOW;
      hi6   <= y5 >= Y_HIGH;
      u6    <= 22'(y5 - Y_LOW);
      poly6 <= poly5;
      pass6 <= pass5;
    end
    // 7: divide by 1000 via reciprocal
    if (en[7]) begin
      q7    <= prod6[43:32];
      lo7   <= lo6;
      hi7   <= hi6;
      poly7 <= poly6;
      pass7 <= pass6;
    end
    // 8: grade and output register
    if (en[8]) begin
      result.apparent_temp <= apparent7;
      result.comfort_level <= level7;
    end
  end

  a_u_range: assert property (@(posedge clk) disable iff (rst)
    vld[6] && poly6 && !lo6 && !hi6 |-> u6 < 22'd2901000)
    else $error("offset heat index out of divider range");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.apparent_temp >= OUT_LOW) && (result.apparent_temp <= OUT_HIGH))
    else $error("apparent_temp outside saturation range");

  a_level: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.comfort_level <= LVL_HOT)
    else $error("comfort_level code out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    vld[4] && !en[5] |=> vld[4] && $stable(sum5) && $stable(acc4))
    else $error("stalled stage lost its beat");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[1] |-> sample_ready)
    else $error("empty entry stage refused a beat");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import hic_pkg::*;

  localparam int unsigned FRAC_BITS = 24;
  localparam int APPARENT_MIN = -400;
  localparam int APPARENT_MAX = 2500;
  localparam int DRAIN_CYCLES = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 135;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  sample_t sample = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfg_t model_cfg;
  sample_t pending_samples[$];
  result_t expected_results[$];
  int queued_count = 0;
  int checked_count = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;
  logic next_valid;
  sample_t next_sample;
  result_t want;

  heat_index_comfort_classifier_core #(
    .COEF_FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // regression coefficient magnitudes, scaled by 2^32
  function automatic longint coef_mag32(input int i);
    case (i)
      0: return 64'd37729976680;
      1: return 64'd6920884003;
      2: return 64'd10043990783;
      3: return 64'd627563656;
      4: return 64'd52862861;
      5: return 64'd70544099;
      6: return 64'd9499317;
      7: return 64'd3115827;
      default: return 64'd15385;
    endcase
  endfunction

  function automatic longint coef_fixed(input int i);
    longint m;
    int unsigned sh;
    m = coef_mag32(i);
    sh = 32 - FRAC_BITS;
    if (sh > 0) begin
      m = (m + (longint'(1) << (sh - 1))) >>> sh;
    end
    return m;
  endfunction

  // exact sum is HI * 10^4 * 2^FRAC; scale back to tenths, round half up
  function automatic longint heat_index_tenths(input longint t, input longint h);
    longint acc;
    longint d;
    acc = -coef_fixed(0) * 10000;
    acc += coef_fixed(1) * (t * 1000);
    acc += coef_fixed(2) * (h * 1000);
    acc -= coef_fixed(3) * (t * h * 100);
    acc -= coef_fixed(4) * (t * t * 100);
    acc -= coef_fixed(5) * (h * h * 100);
    acc += coef_fixed(6) * (t * t * h * 10);
    acc += coef_fixed(7) * (t * h * h * 10);
    acc -= coef_fixed(8) * (t * t * h * h);
    d = longint'(1000) << FRAC_BITS;
    acc += d / 2;
    if (acc >= 0) begin
      return acc / d;
    end
    return -((-acc + d - 1) / d);
  endfunction

  function automatic result_t predict_comfort(input sample_t s);
    result_t r;
    longint t;
    longint h;
    longint hi;
    t = longint'($signed(s.temperature));
    h = longint'(s.humidity);
    if (t >= longint'($signed(model_cfg.valid_temp_min)) &&
        h >= longint'(model_cfg.valid_humidity_min)) begin
      hi = heat_index_tenths(t, h);
    end else begin
      hi = t;
    end
    if (hi < APPARENT_MIN) hi = APPARENT_MIN;
    if (hi > APPARENT_MAX) hi = APPARENT_MAX;
    r.apparent_temp = hi[12:0];
    if (hi < longint'($signed(model_cfg.cold_limit))) begin
      r.comfort_level = LVL_COLD;
    end else if (hi < longint'($signed(model_cfg.cool_limit))) begin
      r.comfort_level = LVL_COOL;
    end else if (hi < longint'($signed(model_cfg.comfortable_limit))) begin
      r.comfort_level = LVL_COMFORTABLE;
    end else if (hi < longint'($signed(model_cfg.warm_limit))) begin
      r.comfort_level = LVL_WARM;
    end else begin
      r.comfort_level = LVL_HOT;
    end
    return r;
  endfunction

  task automatic queue_reading(input int t, input int h);
    sample_t s;
    s.temperature = t[10:0];
    s.humidity = h[9:0];
    pending_samples.push_back(s);
    queued_count++;
  endtask

  function automatic int pick_limit();
    case ($urandom_range(0, 3))
      0: return $signed(model_cfg.cold_limit);
      1: return $signed(model_cfg.cool_limit);
      2: return $signed(model_cfg.comfortable_limit);
      default: return $signed(model_cfg.warm_limit);
    endcase
  endfunction

  task automatic queue_random_reading();
    int t;
    int h;
    case ($urandom_range(0, 9))
      0: begin
        t = $urandom;
        h = $urandom;
      end
      1, 2: begin
        t = $signed(model_cfg.valid_temp_min) + int'($urandom_range(0, 6)) - 3;
        h = int'(model_cfg.valid_humidity_min) + int'($urandom_range(0, 6)) - 3;
      end
      3: begin
        // temperatures near a grading limit
        t = pick_limit() + int'($urandom_range(0, 4)) - 2;
        h = $urandom_range(0, 1000);
      end
      default: begin
        t = int'($urandom_range(0, 1200)) - 400;
        h = $urandom_range(0, 1000);
      end
    endcase
    queue_reading(t, h);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_VALID_TEMP_MIN: model_cfg.valid_temp_min = val[10:0];
      CFG_VALID_HUMIDITY_MIN: model_cfg.valid_humidity_min = val[9:0];
      CFG_COLD_LIMIT: model_cfg.cold_limit = val[12:0];
      CFG_COOL_LIMIT: model_cfg.cool_limit = val[12:0];
      CFG_COMFORTABLE_LIMIT: model_cfg.comfortable_limit = val[12:0];
      CFG_WARM_LIMIT: model_cfg.warm_limit = val[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_thresholds(input int tmin, input int hmin, input int c0,
                                input int c1, input int c2, input int c3);
    write_reg(CFG_VALID_TEMP_MIN, tmin);
    write_reg(CFG_VALID_HUMIDITY_MIN, hmin);
    write_reg(CFG_COLD_LIMIT, c0);
    write_reg(CFG_COOL_LIMIT, c1);
    write_reg(CFG_COMFORTABLE_LIMIT, c2);
    write_reg(CFG_WARM_LIMIT, c3);
  endtask

  task automatic set_random_thresholds();
    int base;
    if ($urandom_range(0, 3) == 0) begin
      set_thresholds($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if ($urandom_range(0, 1) == 0) begin
      base = int'($urandom_range(0, 1000)) - 400;
      set_thresholds(int'($urandom_range(0, 1200)) - 400, $urandom_range(0, 1000),
                     base, base + int'($urandom_range(0, 300)),
                     base + int'($urandom_range(300, 600)),
                     base + int'($urandom_range(600, 1500)));
    end else begin
      set_thresholds(int'($urandom_range(0, 1200)) - 400, $urandom_range(0, 1000),
                     int'($urandom_range(0, 2900)) - 400,
                     int'($urandom_range(0, 2900)) - 400,
                     int'($urandom_range(0, 2900)) - 400,
                     int'($urandom_range(0, 2900)) - 400);
    end
  endtask

  task automatic wait_drained();
    while (checked_count != queued_count) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      gap_left = 0;
    end else begin
      next_valid = sample_valid;
      next_sample = sample;
      if (sample_valid && sample_ready) begin
        expected_results.push_back(predict_comfort(sample));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_samples.size() > 0) begin
          if (idle_on && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 16);
          end else begin
            next_valid = 1'b1;
            next_sample = pending_samples.pop_front();
          end
        end
      end
      sample_valid <= next_valid;
      sample <= next_sample;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: apparent_temp %0d level %0d",
                   $time, $signed(result.apparent_temp), result.comfort_level);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          if (result.apparent_temp !== want.apparent_temp) begin
            $display("%0t: apparent_temp expected %0d actual %0d", $time,
                     $signed(want.apparent_temp), $signed(result.apparent_temp));
            error_count++;
          end
          if (result.comfort_level !== want.comfort_level) begin
            $display("%0t: comfort_level expected %0d actual %0d", $time,
                     want.comfort_level, result.comfort_level);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 16);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    model_cfg.valid_temp_min = 11'sd200;
    model_cfg.valid_humidity_min = 10'd400;
    model_cfg.cold_limit = 13'sd100;
    model_cfg.cool_limit = 13'sd200;
    model_cfg.comfortable_limit = 13'sd280;
    model_cfg.warm_limit = 13'sd350;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults: field extremes, validity edges, grading edges
    queue_reading(-1024, 0);
    queue_reading(1023, 1023);
    queue_reading(-1024, 1023);
    queue_reading(1023, 0);
    queue_reading(1023, 400);
    queue_reading(-401, 0);
    queue_reading(-400, 500);
    queue_reading(800, 1000);
    queue_reading(800, 0);
    queue_reading(200, 400);
    queue_reading(199, 400);
    queue_reading(200, 399);
    queue_reading(0, 0);
    queue_reading(-1, 1023);
    queue_reading(99, 0);
    queue_reading(100, 0);
    queue_reading(199, 0);
    queue_reading(279, 0);
    queue_reading(280, 0);
    queue_reading(349, 0);
    queue_reading(350, 0);
    queue_reading(250, 600);
    queue_reading(300, 500);
    queue_reading(700, 1000);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_thresholds(-400, 0, -400, 0, 500, 2500);
        1: set_thresholds(800, 1000, 2500, 2500, 2500, 2500);
        2: begin
          // out-of-order limits; spare register indexes must be ignored
          set_thresholds(-1024, 0, 1500, 200, 800, -100);
          write_reg(CFG_SPARE_LO, $urandom);
          write_reg(CFG_SPARE_HI, $urandom);
        end
        3: set_thresholds(1023, 1023, -4096, -4096, 4095, 4095);
        PHASES - 1: set_thresholds(270, 400, 150, 220, 300, 400);
        default: set_random_thresholds();
      endcase
      idle_on = (ph != PHASES - 1);
      if (ph == 0) begin
        queue_reading(-400, 1000);
        queue_reading(-1024, 1023);
        queue_reading(-400, 0);
      end
      repeat (ITEMS_PER_PHASE) queue_random_reading();
      wait_drained();
    end

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
